[hdl/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/asa_pkg.sv]
`default_nettype none

package asa_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 256;
  localparam int TOTAL_BITS    = 48;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int OCC_W         = $clog2(TABLE_ENTRIES + 1);

  // Fixed field widths on the channels.
  localparam int KEY_BITS       = 32;
  localparam int SIZE_BITS      = 32;
  localparam int COUNT_BITS     = 32;
  localparam int INDEX_OUT_BITS = 8;
  localparam int TOTAL_OUT_BITS = 48;
  localparam int OCC_OUT_BITS   = 9;

  // Request codes.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
    logic [TOTAL_BITS-1:0] total;
  } asa_entry_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } asa_state_t;

endpackage

`default_nettype wire

[hdl/asa_req_if.sv]
`default_nettype none

// Request channel: one beat per allocation record or clear command.
interface asa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [asa_pkg::KEY_BITS-1:0]   alloc_key;
  logic [asa_pkg::SIZE_BITS-1:0]  alloc_size;

  modport source (output valid, output req_type, output alloc_key, output alloc_size,
                  input ready);
  modport sink   (input valid, input req_type, input alloc_key, input alloc_size,
                  output ready);
endinterface

`default_nettype wire

[hdl/asa_rsp_if.sv]
`default_nettype none

// Result channel: one beat per accepted request.
interface asa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [asa_pkg::INDEX_OUT_BITS-1:0]  entry_index;
  logic                                was_hit;
  logic [asa_pkg::COUNT_BITS-1:0]      entry_count;
  logic [asa_pkg::TOTAL_OUT_BITS-1:0]  entry_total;
  logic [asa_pkg::OCC_OUT_BITS-1:0]    occupancy;
  logic                                dropped;

  modport source (output valid, output entry_index, output was_hit, output entry_count,
                  output entry_total, output occupancy, output dropped, input ready);
  modport sink   (input valid, input entry_index, input was_hit, input entry_count,
                  input entry_total, input occupancy, input dropped, output ready);
endinterface

`default_nettype wire

[hdl/alloc_site_aggregator_unit.sv]
`default_nettype none
`include "assert_macros.svh"

// Allocation site aggregator. Each add beat is looked up by key in a table held in a
// single-port-read, single-port-write entry memory; entries are searched in insertion
// order, one key per cycle, and the first match has its count and byte total bumped
// (both saturate). A miss appends a new entry, or is flagged as dropped when the table
// is full. A clear beat empties the table by zeroing the occupancy count. A clear, or an
// add to an empty table, needs no search; any other add has the memory's one read port
// walk the keys, and no new request is taken until that search ends. The result sits
// in an output register, and the next request is taken in the cycle that register
// drains. No clearing pass is needed after reset.
module alloc_site_aggregator_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  asa_req_if.sink     req,
  asa_rsp_if.source   rsp
);

  localparam int IDX_W = asa_pkg::IDX_W;
  localparam int OCC_W = asa_pkg::OCC_W;
  localparam int TB    = asa_pkg::TOTAL_BITS;

  // Entry memory.
  asa_pkg::asa_entry_t mem [asa_pkg::TABLE_ENTRIES];
  asa_pkg::asa_entry_t rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  asa_pkg::asa_entry_t wr_data;

  // Control state.
  asa_pkg::asa_state_t state, state_next;
  logic [OCC_W-1:0]    used, used_next;
  logic [IDX_W-1:0]    scan_addr, scan_addr_next;
  logic [asa_pkg::KEY_BITS-1:0]  key_reg;
  logic [asa_pkg::SIZE_BITS-1:0] size_reg;

  // Output register.
  logic                                out_valid;
  logic [asa_pkg::INDEX_OUT_BITS-1:0]  out_index;
  logic                                out_hit;
  logic [asa_pkg::COUNT_BITS-1:0]      out_count;
  logic [asa_pkg::TOTAL_OUT_BITS-1:0]  out_total;
  logic [asa_pkg::OCC_OUT_BITS-1:0]    out_occ;
  logic                                out_drop;

  // Result about to be loaded.
  logic                                load_res;
  logic [asa_pkg::INDEX_OUT_BITS-1:0]  res_index;
  logic                                res_hit;
  logic [asa_pkg::COUNT_BITS-1:0]      res_count;
  logic [asa_pkg::TOTAL_OUT_BITS-1:0]  res_total;
  logic [asa_pkg::OCC_OUT_BITS-1:0]    res_occ;
  logic                                res_drop;

  logic          accept;
  logic          in_scan;
  logic          key_hit;
  logic          scan_last;
  logic          table_full;
  logic [asa_pkg::COUNT_BITS-1:0] count_inc;
  logic [TB:0]   sum_wide;
  logic [TB-1:0] sum_sat;

  // Handshake: a request is taken when idle and the output slot is free or draining.
  assign req.ready = (state == asa_pkg::ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign in_scan   = (state == asa_pkg::ST_SCAN);

  // Compare and update arithmetic on the entry that was read last cycle.
  assign key_hit    = (rd_data.key == key_reg);
  assign scan_last  = ((OCC_W'(scan_addr) + OCC_W'(1)) == used);
  assign table_full = (used == OCC_W'(asa_pkg::TABLE_ENTRIES));
  assign count_inc  = (&rd_data.count) ? rd_data.count : rd_data.count + 1'b1;
  assign sum_wide   = {1'b0, rd_data.total} + (TB + 1)'(size_reg);
  assign sum_sat    = sum_wide[TB] ? {TB{1'b1}} : sum_wide[TB-1:0];

  // Memory read port: registered read data.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      asa_pkg::ST_IDLE: begin
        if (accept && (req.req_type == asa_pkg::REQ_ADD) && (used != '0)) begin
          state_next = asa_pkg::ST_SCAN;
        end
      end
      asa_pkg::ST_SCAN: begin
        if (key_hit || scan_last) begin
          state_next = asa_pkg::ST_IDLE;
        end
      end
      default: state_next = asa_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses, counters and the result for the output register.
  always_comb begin
    rd_addr        = scan_addr + 1'b1;
    wr_en          = 1'b0;
    wr_addr        = scan_addr;
    wr_data        = '0;
    used_next      = used;
    scan_addr_next = scan_addr;
    load_res       = 1'b0;
    res_index      = '0;
    res_hit        = 1'b0;
    res_count      = '0;
    res_total      = '0;
    res_occ        = '0;
    res_drop       = 1'b0;
    unique case (state)
      asa_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.req_type == asa_pkg::REQ_CLEAR) begin
            used_next = '0;
            load_res  = 1'b1;
          end else if (used == '0) begin
            // Empty table: append at slot zero without a search.
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.key   = req.alloc_key;
            wr_data.count = asa_pkg::COUNT_BITS'(1);
            wr_data.total = TB'(req.alloc_size);
            used_next     = OCC_W'(1);
            load_res      = 1'b1;
            res_count     = asa_pkg::COUNT_BITS'(1);
            res_total     = asa_pkg::TOTAL_OUT_BITS'(req.alloc_size);
            res_occ       = asa_pkg::OCC_OUT_BITS'(1);
          end else begin
            rd_addr        = '0;
            scan_addr_next = '0;
          end
        end
      end
      asa_pkg::ST_SCAN: begin
        if (key_hit) begin
          // First match: bump count and total in place.
          wr_en         = 1'b1;
          wr_addr       = scan_addr;
          wr_data.key   = rd_data.key;
          wr_data.count = count_inc;
          wr_data.total = sum_sat;
          load_res      = 1'b1;
          res_index     = asa_pkg::INDEX_OUT_BITS'(scan_addr);
          res_hit       = 1'b1;
          res_count     = count_inc;
          res_total     = asa_pkg::TOTAL_OUT_BITS'(sum_sat);
          res_occ       = asa_pkg::OCC_OUT_BITS'(used);
        end else if (scan_last) begin
          load_res = 1'b1;
          res_occ  = asa_pkg::OCC_OUT_BITS'(used);
          if (table_full) begin
            res_drop = 1'b1;
          end else begin
            // Miss with room left: append after the last occupied entry.
            wr_en         = 1'b1;
            wr_addr       = used[IDX_W-1:0];
            wr_data.key   = key_reg;
            wr_data.count = asa_pkg::COUNT_BITS'(1);
            wr_data.total = TB'(size_reg);
            used_next     = used + 1'b1;
            res_index     = asa_pkg::INDEX_OUT_BITS'(used);
            res_count     = asa_pkg::COUNT_BITS'(1);
            res_total     = asa_pkg::TOTAL_OUT_BITS'(size_reg);
            res_occ       = asa_pkg::OCC_OUT_BITS'(used + 1'b1);
          end
        end else begin
          scan_addr_next = scan_addr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= asa_pkg::ST_IDLE;
      used      <= '0;
      scan_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      scan_addr <= scan_addr_next;
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg  <= req.alloc_key;
      size_reg <= req.alloc_size;
    end
    if (load_res) begin
      out_index <= res_index;
      out_hit   <= res_hit;
      out_count <= res_count;
      out_total <= res_total;
      out_occ   <= res_occ;
      out_drop  <= res_drop;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.entry_index = out_index;
  assign rsp.was_hit     = out_hit;
  assign rsp.entry_count = out_count;
  assign rsp.entry_total = out_total;
  assign rsp.occupancy   = out_occ;
  assign rsp.dropped     = out_drop;

  // Checks on the sequencer and the table.
  `ASSERT_CLK(a_used_in_range, used <= OCC_W'(asa_pkg::TABLE_ENTRIES), "occupancy overflow")
  `ASSERT_CLK(a_scan_out_empty, in_scan |-> !out_valid, "result busy in scan")
  `ASSERT_CLK(a_scan_in_table, in_scan |-> (OCC_W'(scan_addr) < used), "scan beyond table")
  `ASSERT_CLK(a_drop_when_full, (load_res && res_drop) |=> table_full, "drop with room left")

endmodule

`default_nettype wire
